@@ rtl/led_grid_quadrant_refresh_encoder_assert.svh @@
// Assertion macros shared by the queue and back-end modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LED_GRID_QUADRANT_REFRESH_ENCODER_ASSERT_SVH
`define LED_GRID_QUADRANT_REFRESH_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property outside reset.
`define LGQRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every edge, reset included.
`define LGQRE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGQRE_ASSERT(lbl, prop, msg)
`define LGQRE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/lgqre_pkg.sv @@
package lgqre_pkg;

  localparam int LED_COUNT = 256;
  // LED store organized as half rows of eight LEDs
  localparam int HALF_ROW_COUNT = LED_COUNT / 8;
  localparam int ROW_AW = $clog2(HALF_ROW_COUNT);

  localparam logic [4:0] QUAD_SIDE = 5'd8;
  localparam logic [7:0] CMD_EXTENDED = 8'h14;
  localparam logic [7:0] CMD_SERIES = 8'h80;
  localparam logic [7:0] QUAD_ORIGIN_HI = 8'd8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  localparam logic PROTO_SERIES = 1'b0;
  localparam logic PROTO_EXTENDED = 1'b1;

  localparam logic [1:0] CFG_PROTOCOL = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [1:0] CFG_GRID_ROWS = 2'd2;

  typedef struct packed {
    logic       protocol;
    logic [4:0] grid_cols;
    logic [4:0] grid_rows;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic              refresh;
    logic [ROW_AW-1:0] row_addr;
    logic [2:0]        bit_sel;
    logic              on;
    logic [3:0]        quad_bit;
  } cmd_t;

  // Lowest pending quadrant
  function automatic logic [1:0] lowest_quad(input logic [3:0] mask);
    logic [1:0] q;
    q = 2'd3;
    if (mask[2]) q = 2'd2;
    if (mask[1]) q = 2'd1;
    if (mask[0]) q = 2'd0;
    return q;
  endfunction

endpackage

@@ rtl/lgqre_front.sv @@
module lgqre_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [3:0]          led_x,
  input  logic [3:0]          led_y,
  input  logic [7:0]          led_level,
  input  logic                q_full,
  output logic                push,
  output lgqre_pkg::cmd_t     push_cmd
);

  logic            fr_valid;
  lgqre_pkg::cmd_t fr_cmd;
  lgqre_pkg::cmd_t cmd_next;
  logic            accept;

  // Classify the incoming beat
  always_comb begin
    cmd_next.refresh  = (op == lgqre_pkg::OP_REFRESH);
    cmd_next.row_addr = {led_y, led_x[3]};
    cmd_next.bit_sel  = led_x[2:0];
    cmd_next.on       = (led_level != 8'd0);
    cmd_next.quad_bit = 4'b0001 << {led_y[3], led_x[3]};
  end

  assign in_stall = fr_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid && !q_full;
  assign push_cmd = fr_cmd;

  // Hold one classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (accept) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd <= cmd_next;
    end
  end

endmodule

@@ rtl/lgqre_queue.sv @@
module lgqre_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lgqre_pkg::cmd_t     push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output lgqre_pkg::cmd_t     head
);

`include "led_grid_quadrant_refresh_encoder_assert.svh"

  lgqre_pkg::cmd_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `LGQRE_ASSERT_ALWAYS(a_count_range, (rst || count <= 2'd2), "queue occupancy out of range")
  `LGQRE_ASSERT(a_no_overflow, push |-> (count != 2'd2 || pop), "push into full queue")
  `LGQRE_ASSERT(a_no_underflow, pop |-> (count != 2'd0), "pop from empty queue")

endmodule

@@ rtl/lgqre_back.sv @@
module lgqre_back (
  input  logic                clk,
  input  logic                rst,
  input  lgqre_pkg::cfg_t     cfg,
  input  logic                head_valid,
  input  lgqre_pkg::cmd_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          tx_byte,
  output logic                last
);

`include "led_grid_quadrant_refresh_encoder_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_ROW_ADDR,
    ST_ROW_OUT
  } state_t;

  state_t     state;
  logic [3:0] dirty;
  logic [3:0] pend;
  logic [1:0] cur;
  logic [1:0] hcnt;
  logic [2:0] rrow;

  // LED store: half rows with per-entry valid bits
  logic [7:0]                         mem [lgqre_pkg::HALF_ROW_COUNT];
  logic [lgqre_pkg::HALF_ROW_COUNT-1:0] row_valid;
  logic [7:0]                         rd_data;
  logic [lgqre_pkg::ROW_AW-1:0]       rd_addr;

  logic       can_load;
  logic       out_load;
  logic       do_write;
  logic       do_refresh;
  logic [3:0] allow;
  logic [3:0] start_pend;
  logic [3:0] rest;
  logic [7:0] hdr_byte;
  logic       hdr_done;
  logic       run_end;

  assign can_load   = !out_valid || !out_stall;
  assign out_load   = can_load && (state == ST_HDR || state == ST_ROW_OUT);
  assign pop        = (state == ST_IDLE) && head_valid;
  assign do_write   = pop && !head.refresh;
  assign do_refresh = pop && head.refresh;

  // Quadrants the grid size enables
  always_comb begin
    allow[0] = 1'b1;
    allow[1] = (cfg.grid_cols > lgqre_pkg::QUAD_SIDE);
    allow[2] = (cfg.grid_rows > lgqre_pkg::QUAD_SIDE);
    allow[3] = allow[1] && allow[2];
  end

  assign start_pend = dirty & allow;
  assign rest       = pend & ~(4'b0001 << cur);
  assign rd_addr    = {cur[1], rrow, cur[0]};
  assign run_end    = (rrow == 3'd7) && (rest == 4'd0);

  // Header byte for the current quadrant
  always_comb begin
    hdr_byte = lgqre_pkg::CMD_SERIES | {6'd0, cur};
    hdr_done = 1'b1;
    if (cfg.protocol == lgqre_pkg::PROTO_EXTENDED) begin
      hdr_done = (hcnt == 2'd2);
      case (hcnt)
        2'd0:    hdr_byte = lgqre_pkg::CMD_EXTENDED;
        2'd1:    hdr_byte = cur[0] ? lgqre_pkg::QUAD_ORIGIN_HI : 8'd0;
        default: hdr_byte = cur[1] ? lgqre_pkg::QUAD_ORIGIN_HI : 8'd0;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dirty     <= 4'd0;
      pend      <= 4'd0;
      cur       <= 2'd0;
      hcnt      <= 2'd0;
      rrow      <= 3'd0;
      out_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      // Raise valid on a new beat, drop it once the beat is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (do_write) begin
            dirty <= dirty | head.quad_bit;
          end else if (do_refresh && start_pend != 4'd0) begin
            dirty <= dirty & ~start_pend;
            pend  <= start_pend;
            cur   <= lgqre_pkg::lowest_quad(start_pend);
            hcnt  <= 2'd0;
            state <= ST_HDR;
          end
        end
        ST_HDR: begin
          if (can_load) begin
            tx_byte   <= hdr_byte;
            last      <= 1'b0;
            if (hdr_done) begin
              rrow  <= 3'd0;
              state <= ST_ROW_ADDR;
            end else begin
              hcnt <= hcnt + 2'd1;
            end
          end
        end
        ST_ROW_ADDR: begin
          state <= ST_ROW_OUT;
        end
        ST_ROW_OUT: begin
          if (can_load) begin
            tx_byte   <= rd_data;
            last      <= run_end;
            if (rrow == 3'd7) begin
              pend <= rest;
              if (rest == 4'd0) begin
                state <= ST_IDLE;
              end else begin
                cur   <= lgqre_pkg::lowest_quad(rest);
                hcnt  <= 2'd0;
                state <= ST_HDR;
              end
            end else begin
              rrow  <= rrow + 3'd1;
              state <= ST_ROW_ADDR;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Track which half rows hold written data
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (do_write) begin
      row_valid[head.row_addr] <= 1'b1;
    end
  end

  // Write one LED; a fresh half row starts from all off
  always_ff @(posedge clk) begin
    if (do_write) begin
      if (row_valid[head.row_addr]) begin
        mem[head.row_addr][head.bit_sel] <= head.on;
      end else begin
        mem[head.row_addr] <= {7'd0, head.on} << head.bit_sel;
      end
    end
  end

  // Registered read of one row byte
  always_ff @(posedge clk) begin
    if (state == ST_ROW_ADDR) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : 8'd0;
    end
  end

  `LGQRE_ASSERT(a_hdr_pending, (state == ST_HDR) |-> (pend != 4'd0), "header with no quadrant pending")
  `LGQRE_ASSERT(a_last_ends_run, (state == ST_ROW_OUT && can_load && run_end) |=> (state == ST_IDLE && last && out_valid), "final row byte did not close the run")
  `LGQRE_ASSERT(a_no_pop_busy, pop |-> (state == ST_IDLE), "queue popped while a refresh is running")

endmodule

@@ rtl/led_grid_quadrant_refresh_encoder.sv @@
// Channel   Handshake              Payload
// in        in_valid / in_stall    op, led_x, led_y, led_level
// out       out_valid / out_stall  tx_byte, last
// cfg       cfg_we                 cfg_addr, cfg_wdata
//
// The back end stores a write when idle; front and two-entry queue stream writes at one per
// cycle while no refresh runs. A refresh sends, per quadrant, a 3-byte (extended) or 1-byte
// (series) header and 8 row bytes, each read then output on the single store read port.
// Reset clears the dirty flags and 32 half-row valid bits directly; no clearing pass.
// A stalled output holds the sequencer; the front keeps accepting until the queue fills.
module led_grid_quadrant_refresh_encoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [3:0] led_x,
  input  logic [3:0] led_y,
  input  logic [7:0] led_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last
);

  lgqre_pkg::cfg_t cfg;
  lgqre_pkg::cmd_t push_cmd;
  lgqre_pkg::cmd_t head;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol  <= lgqre_pkg::PROTO_EXTENDED;
      cfg.grid_cols <= 5'd0;
      cfg.grid_rows <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lgqre_pkg::CFG_PROTOCOL:  cfg.protocol  <= cfg_wdata[0];
        lgqre_pkg::CFG_GRID_COLS: cfg.grid_cols <= cfg_wdata;
        lgqre_pkg::CFG_GRID_ROWS: cfg.grid_rows <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lgqre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .led_x     (led_x),
    .led_y     (led_y),
    .led_level (led_level),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  lgqre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lgqre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_byte    (tx_byte),
    .last       (last)
  );

endmodule

@@ verif/led_grid_quadrant_refresh_encoder_test.sv @@
`timescale 1ns / 100ps

module led_grid_quadrant_refresh_encoder_test;
  import lgqre_pkg::*;

  typedef struct packed {
    logic       op;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] level;
  } grid_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } tx_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [4:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       op = OP_WRITE;
  logic [3:0] led_x = '0;
  logic [3:0] led_y = '0;
  logic [7:0] led_level = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] tx_byte;
  logic       last;

  led_grid_quadrant_refresh_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .led_x     (led_x),
    .led_y     (led_y),
    .led_level (led_level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .last      (last)
  );

  always #5 clk = ~clk;

  // Expected LED map and encoder settings
  logic [15:0] led_rows [16];
  logic [3:0]  quad_dirty;
  logic        set_protocol;
  logic [4:0]  set_cols;
  logic [4:0]  set_rows;

  grid_cmd_t pending_cmds [$];
  tx_beat_t  frame_bytes_due [$];

  logic in_taken = 1'b0;
  int   cmd_gap_pct = 0;
  int   cmd_gap_left = 0;
  int   stall_pct = 0;
  int   stall_left = 0;

  int mismatch_count = 0;
  int write_count = 0;
  int refresh_count = 0;
  int framed_refresh_count = 0;
  int bytes_checked = 0;
  int settings_count = 0;

  // Update one LED and mark its quadrant dirty
  task automatic store_led(input logic [3:0] x, input logic [3:0] y, input logic [7:0] level);
    led_rows[y][x] = (level != 8'd0);
    quad_dirty[{y[3], x[3]}] = 1'b1;
  endtask

  // Build the byte run for every dirty quadrant that the grid size allows
  task automatic encode_refresh();
    tx_beat_t run [$];
    logic     wide;
    logic     tall;
    logic     allowed;
    int       ox;
    int       oy;
    wide = set_cols > QUAD_SIDE;
    tall = set_rows > QUAD_SIDE;
    for (int q = 0; q < 4; q++) begin
      case (q)
        0: allowed = 1'b1;
        1: allowed = wide;
        2: allowed = tall;
        default: allowed = wide && tall;
      endcase
      if (quad_dirty[q] && allowed) begin
        ox = q[0] ? 8 : 0;
        oy = q[1] ? 8 : 0;
        if (set_protocol == PROTO_EXTENDED) begin
          run.push_back('{CMD_EXTENDED, 1'b0});
          run.push_back('{8'(ox), 1'b0});
          run.push_back('{8'(oy), 1'b0});
        end else begin
          run.push_back('{CMD_SERIES | 8'(q), 1'b0});
        end
        for (int r = 0; r < 8; r++)
          run.push_back('{led_rows[oy + r][ox +: 8], 1'b0});
        quad_dirty[q] = 1'b0;
      end
    end
    if (run.size() != 0) begin
      run[run.size() - 1].fin = 1'b1;
      framed_refresh_count++;
    end
    foreach (run[i]) frame_bytes_due.push_back(run[i]);
  endtask

  task automatic report_mismatch(input string what, input tx_beat_t want, input tx_beat_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected byte %02h last %0b, got byte %02h last %0b",
               what, want.data, want.fin, got.data, got.fin);
  endtask

  // Note accepted command beats and predict their frame bytes
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (op == OP_WRITE) begin
          write_count++;
          store_led(led_x, led_y, led_level);
        end else begin
          refresh_count++;
          encode_refresh();
        end
      end
    end
  end

  // Present the next command beat; hold it until the block takes it
  always @(negedge clk) begin : drive_cmd
    grid_cmd_t nxt;
    logic      show;
    nxt = {op, led_x, led_y, led_level};
    show = 1'b0;
    if (rst) begin
      show = 1'b0;
    end else if (in_valid && !in_taken) begin
      show = 1'b1;
    end else if (cmd_gap_left != 0) begin
      cmd_gap_left--;
    end else if (pending_cmds.size() != 0) begin
      if ($urandom_range(0, 99) < cmd_gap_pct) begin
        cmd_gap_left = $urandom_range(0, 6);
      end else begin
        nxt = pending_cmds.pop_front();
        show = 1'b1;
      end
    end
    in_valid <= show;
    {op, led_x, led_y, led_level} <= nxt;
  end

  // Stall the output in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!rst && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each output beat with the oldest predicted byte
  always @(posedge clk) begin : check_out
    tx_beat_t want;
    tx_beat_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{tx_byte, last};
      bytes_checked++;
      if (frame_bytes_due.size() == 0) begin
        report_mismatch("unexpected byte", '0, got);
      end else begin
        want = frame_bytes_due.pop_front();
        if (want !== got) report_mismatch("frame byte", want, got);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROTOCOL:  set_protocol = val[0];
      CFG_GRID_COLS: set_cols = val;
      CFG_GRID_ROWS: set_rows = val;
      default: ;
    endcase
  endtask

  task automatic push_cmd(input logic o, input logic [3:0] x, input logic [3:0] y,
                          input logic [7:0] level);
    pending_cmds.push_back('{o, x, y, level});
  endtask

  // Wait for all beats to go in and all bytes to come out, then let the block settle
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid || frame_bytes_due.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_phase(input logic proto, input logic [4:0] cols, input logic [4:0] rows,
                           input int gap_pct, input int hold_pct, input int count);
    grid_cmd_t c;
    write_reg(CFG_PROTOCOL, {4'd0, proto});
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_GRID_ROWS, rows);
    settings_count++;
    cmd_gap_pct = gap_pct;
    stall_pct = hold_pct;
    for (int i = 0; i < count; i++) begin
      c.op = ($urandom_range(0, 99) < 15) ? OP_REFRESH : OP_WRITE;
      c.x = 4'($urandom_range(0, 15));
      c.y = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: c.level = 8'd0;
        1: c.level = 8'hFF;
        default: c.level = 8'($urandom_range(1, 255));
      endcase
      pending_cmds.push_back(c);
    end
    // close each phase with a refresh so that the last writes get sent
    push_cmd(OP_REFRESH, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
             8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  initial begin
    foreach (led_rows[i]) led_rows[i] = '0;
    quad_dirty = '0;
    set_protocol = PROTO_EXTENDED;
    set_cols = '0;
    set_rows = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: extended frames, only the upper-left quadrant enabled
    settings_count++;
    cmd_gap_pct = 20;
    stall_pct = 20;
    push_cmd(OP_REFRESH, 4'd0, 4'd0, 8'd0);
    push_cmd(OP_WRITE, 4'd0, 4'd0, 8'hFF);
    push_cmd(OP_WRITE, 4'd15, 4'd15, 8'h01);
    push_cmd(OP_WRITE, 4'd8, 4'd0, 8'h80);
    push_cmd(OP_WRITE, 4'd7, 4'd8, 8'h00);
    push_cmd(OP_WRITE, 4'd7, 4'd7, 8'h02);
    push_cmd(OP_REFRESH, 4'd15, 4'd15, 8'hFF);
    push_cmd(OP_REFRESH, 4'd0, 4'd0, 8'd0);
    wait_idle();

    // Open the full grid: the skipped quadrants are still dirty
    write_reg(CFG_GRID_COLS, 5'd16);
    write_reg(CFG_GRID_ROWS, 5'd16);
    write_reg(2'd3, 5'd31);
    settings_count++;
    push_cmd(OP_REFRESH, 4'd0, 4'd0, 8'd0);
    wait_idle();

    // Series frames, one dirty LED per quadrant plus corner cases
    write_reg(CFG_PROTOCOL, {4'd0, PROTO_SERIES});
    write_reg(CFG_GRID_COLS, 5'd9);
    write_reg(CFG_GRID_ROWS, 5'd31);
    settings_count++;
    push_cmd(OP_WRITE, 4'd0, 4'd15, 8'h01);
    push_cmd(OP_WRITE, 4'd15, 4'd8, 8'h02);
    push_cmd(OP_WRITE, 4'd7, 4'd7, 8'h04);
    push_cmd(OP_WRITE, 4'd8, 4'd8, 8'h08);
    push_cmd(OP_WRITE, 4'd3, 4'd12, 8'h10);
    push_cmd(OP_WRITE, 4'd12, 4'd3, 8'h20);
    push_cmd(OP_WRITE, 4'd0, 4'd0, 8'h40);
    push_cmd(OP_WRITE, 4'd15, 4'd15, 8'h00);
    push_cmd(OP_REFRESH, 4'd5, 4'd10, 8'h55);
    push_cmd(OP_WRITE, 4'd5, 4'd5, 8'h00);
    push_cmd(OP_REFRESH, 4'd10, 4'd5, 8'hAA);
    wait_idle();

    run_phase(PROTO_EXTENDED, 5'd16, 5'd16, 30, 30, 40);
    run_phase(PROTO_SERIES, 5'd8, 5'd16, 20, 50, 40);
    run_phase(PROTO_EXTENDED, 5'd9, 5'd8, 50, 20, 40);
    run_phase(PROTO_SERIES, 5'd31, 5'd31, 30, 30, 40);
    run_phase(PROTO_EXTENDED, 5'd0, 5'd17, 40, 40, 40);
    run_phase(PROTO_SERIES, 5'd16, 5'd16, 0, 0, 40);

    while (frame_bytes_due.size() != 0)
      report_mismatch("missing byte", frame_bytes_due.pop_front(), '0);

    $display("Checked %0d frame bytes from %0d refreshes (%0d sent frames) and %0d LED writes",
             bytes_checked, refresh_count, framed_refresh_count, write_count);
    $display("across %0d grid settings in both frame formats; %0d mismatches",
             settings_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout waiting for the encoder to finish");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
